[sv/csem_pkg.sv]
// package for the counting semaphore with fifo wait queue
// holds field widths, parameter defaults, controller state type and
// the command/status structs between controller and datapath
`timescale 1ns / 1ps

package csem_pkg;

  localparam int CMD_W  = 1;
  localparam int ID_W   = 16;
  localparam int REL_W  = 16;
  localparam int CNT_W  = 32;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int TASK_ID_BITS_DEF = 16;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WAIT   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SIGNAL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAKE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture the input word
    logic exec;  // evaluate the captured word
    logic pop;   // wake the task at the queue head
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_signal;
    logic rem_zero;
    logic q_empty;
    logic pop_last;
  } sts_t;

endpackage

[sv/csem_ram.sv]
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module csem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/csem_ctrl.sv]
// controller state machine for the semaphore
// uses csem_pkg types; drives datapath commands and the busy flag
`timescale 1ns / 1ps

module csem_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  csem_pkg::sts_t sts,
  output csem_pkg::cmd_t cmd
);

  csem_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csem_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      csem_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = csem_pkg::ST_EXEC;
        end
      end
      csem_pkg::ST_EXEC: begin
        if (sts.is_signal && !sts.rem_zero && !sts.q_empty) begin
          state_nxt = csem_pkg::ST_WAKE;
        end else begin
          state_nxt = csem_pkg::ST_IDLE;
        end
      end
      csem_pkg::ST_WAKE: begin
        if (sts.pop_last) begin
          state_nxt = csem_pkg::ST_IDLE;
        end
      end
      default: state_nxt = csem_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      csem_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      csem_pkg::ST_EXEC: cmd.exec = 1'b1;
      csem_pkg::ST_WAKE: cmd.pop  = 1'b1;
      default: busy = 1'b0;
    endcase
  end

`ifndef NO_ASSERTIONS
  // wake phase only follows a signal word
  a_wake_signal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == csem_pkg::ST_WAKE) |-> sts.is_signal)
    else $error("wake phase without signal word");
`endif

endmodule

[sv/csem_dp.sv]
// datapath for the semaphore: unit counter, queue pointers, waiter count,
// captured word and result registers; uses csem_pkg and csem_ram
`timescale 1ns / 1ps

module csem_dp #(
  parameter int QUEUE_DEPTH  = csem_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_BITS = csem_pkg::TASK_ID_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  csem_pkg::cmd_t              cmd,
  output csem_pkg::sts_t              sts,
  input  logic [csem_pkg::CMD_W-1:0]  in_command,
  input  logic [csem_pkg::ID_W-1:0]   in_task_id,
  input  logic [csem_pkg::REL_W-1:0]  in_release_count,
  input  logic                        cfg_wr_en,
  input  logic [csem_pkg::CNT_W-1:0]  cfg_wr_data,
  output logic                        out_valid,
  output logic                        out_granted,
  output logic                        out_task_valid,
  output logic [csem_pkg::ID_W-1:0]   out_woken_task,
  output logic                        out_queue_full,
  output logic                        out_last
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int TW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = (TASK_ID_BITS < csem_pkg::ID_W) ? TASK_ID_BITS : csem_pkg::ID_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
  localparam logic [TW-1:0] FULL_TOTAL = TW'(QUEUE_DEPTH);

  logic [csem_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]              head_r, head_nxt, tail_r, tail_nxt;
  logic [TW-1:0]              total_r, total_nxt;
  logic [csem_pkg::CMD_W-1:0] cmd_r;
  logic [SW-1:0]              task_r;
  logic [csem_pkg::REL_W-1:0] rem_r, rem_nxt;

  logic                       valid_r, valid_nxt;
  logic                       granted_r, granted_nxt;
  logic                       tvalid_r, tvalid_nxt;
  logic [csem_pkg::ID_W-1:0]  woken_r, woken_nxt;
  logic                       full_r, full_nxt;
  logic                       last_r, last_nxt;

  logic                       ram_we;
  logic [SW-1:0]              ram_rdata;

  logic [csem_pkg::REL_W-1:0] add_val;
  logic [csem_pkg::CNT_W:0]   sum;
  logic [csem_pkg::CNT_W-1:0] sat_sum;
  logic                       is_wait;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    return (i == LAST_SLOT) ? '0 : AW'(i + 1'b1);
  endfunction

  assign is_wait = (cmd_r == csem_pkg::CMD_WAIT);

  assign sts.is_signal = (cmd_r == csem_pkg::CMD_SIGNAL);
  assign sts.rem_zero  = (rem_r == '0);
  assign sts.q_empty   = (total_r == '0);
  assign sts.pop_last  = (rem_r == csem_pkg::REL_W'(1)) || (total_r == TW'(1));

  // saturating add of released units, one adder shared by both cases
  assign add_val = cmd.pop ? csem_pkg::REL_W'(rem_r - 1'b1) : rem_r;
  assign sum     = {1'b0, cnt_r} + (csem_pkg::CNT_W + 1)'(add_val);
  assign sat_sum = sum[csem_pkg::CNT_W] ? csem_pkg::COUNT_MAX : sum[csem_pkg::CNT_W-1:0];

  always_comb begin
    cnt_nxt     = cnt_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    total_nxt   = total_r;
    rem_nxt     = rem_r;
    ram_we      = 1'b0;
    valid_nxt   = 1'b0;
    granted_nxt = 1'b0;
    tvalid_nxt  = 1'b0;
    woken_nxt   = '0;
    full_nxt    = 1'b0;
    last_nxt    = 1'b0;

    if (cmd.load) begin
      rem_nxt = in_release_count;
    end

    if (cmd.exec) begin
      if (is_wait) begin
        valid_nxt = 1'b1;
        last_nxt  = 1'b1;
        if (cnt_r != '0) begin
          cnt_nxt     = cnt_r - 1'b1;
          granted_nxt = 1'b1;
        end else if (total_r < FULL_TOTAL) begin
          ram_we    = 1'b1;
          tail_nxt  = next_slot(tail_r);
          total_nxt = TW'(total_r + 1'b1);
        end else begin
          full_nxt = 1'b1;
        end
      end else if (sts.rem_zero) begin
        valid_nxt = 1'b1;
        last_nxt  = 1'b1;
      end else if (sts.q_empty) begin
        valid_nxt   = 1'b1;
        granted_nxt = 1'b1;
        last_nxt    = 1'b1;
        cnt_nxt     = sat_sum;
      end
    end

    if (cmd.pop) begin
      valid_nxt   = 1'b1;
      granted_nxt = 1'b1;
      tvalid_nxt  = 1'b1;
      woken_nxt   = csem_pkg::ID_W'(ram_rdata);
      head_nxt    = next_slot(head_r);
      total_nxt   = TW'(total_r - 1'b1);
      rem_nxt     = csem_pkg::REL_W'(rem_r - 1'b1);
      if (sts.pop_last) begin
        last_nxt = 1'b1;
        cnt_nxt  = sat_sum;
      end
    end

    // register write empties the queue and reloads the counter
    if (cfg_wr_en) begin
      cnt_nxt   = cfg_wr_data;
      head_nxt  = '0;
      tail_nxt  = '0;
      total_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      total_r <= '0;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      total_r <= total_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      task_r <= in_task_id[SW-1:0];
    end
    rem_r     <= rem_nxt;
    granted_r <= granted_nxt;
    tvalid_r  <= tvalid_nxt;
    woken_r   <= woken_nxt;
    full_r    <= full_nxt;
    last_r    <= last_nxt;
  end

  // read address tracks the next head so the head entry is ready each cycle
  csem_ram #(
    .WIDTH (SW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (task_r),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  assign out_valid      = valid_r;
  assign out_granted    = granted_r;
  assign out_task_valid = tvalid_r;
  assign out_woken_task = woken_r;
  assign out_queue_full = full_r;
  assign out_last       = last_r;

`ifndef NO_ASSERTIONS
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= FULL_TOTAL)
    else $error("waiter count above queue depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (total_r != '0) && (rem_r != '0))
    else $error("wake from empty queue or with no units");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.exec || cmd.pop))
    else $error("result strobe without execute or wake");
`endif

endmodule

[sv/counting_semaphore_wait_queue.sv]
// top level of the counting semaphore with fifo wait queue
// instantiates csem_ctrl and csem_dp; uses csem_pkg for widths and defaults
`timescale 1ns / 1ps

//  channel  handshake           payload
//  input    start / busy        in_command, in_task_id, in_release_count
//  result   out_valid strobe    out_granted, out_task_valid, out_woken_task,
//                               out_queue_full, out_last
//  config   cfg_wr_en           cfg_wr_data (initial count)
//
// a word is taken when start is high and busy is low
// wait words and zero-unit signals pass through capture, then execute
// a signal waking tasks passes through capture, execute, then one wake step
// per task: the queue memory's single read port pops one task per cycle
// each result shows on the out_ ports in the cycle after it is produced, for
// exactly one cycle; the receiver has no stall
// synchronous reset clears counter, pointers and waiter count; queue memory
// is not cleared since only written entries are ever read

module counting_semaphore_wait_queue #(
  parameter int QUEUE_DEPTH  = csem_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_BITS = csem_pkg::TASK_ID_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input word
  input  logic                        start,
  output logic                        busy,
  input  logic [csem_pkg::CMD_W-1:0]  in_command,
  input  logic [csem_pkg::ID_W-1:0]   in_task_id,
  input  logic [csem_pkg::REL_W-1:0]  in_release_count,
  // results
  output logic                        out_valid,
  output logic                        out_granted,
  output logic                        out_task_valid,
  output logic [csem_pkg::ID_W-1:0]   out_woken_task,
  output logic                        out_queue_full,
  output logic                        out_last,
  // initial count register
  input  logic                        cfg_wr_en,
  input  logic [csem_pkg::CNT_W-1:0]  cfg_wr_data
);

  csem_pkg::cmd_t cmd;
  csem_pkg::sts_t sts;

  // flow control: idle -> execute -> (wake loop) -> idle
  csem_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // counter, queue and result registers
  csem_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_command       (in_command),
    .in_task_id       (in_task_id),
    .in_release_count (in_release_count),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_granted      (out_granted),
    .out_task_valid   (out_task_valid),
    .out_woken_task   (out_woken_task),
    .out_queue_full   (out_queue_full),
    .out_last         (out_last)
  );

endmodule

[test/counting_semaphore_wait_queue_tb.sv]
// testbench for counting_semaphore_wait_queue: directed table, then random phases
// checked word by word against an in-bench semaphore predictor; needs csem_pkg
// and the rtl of the block only
`timescale 1ns / 1ps

module counting_semaphore_wait_queue_tb;

  localparam int QDEPTH       = csem_pkg::QUEUE_DEPTH_DEF;
  localparam int SETTLE_LIMIT = 2000;   // cycles allowed for the last results to drain
  localparam int TAIL_CYCLES  = 4;      // quiet cycles after the last result
  localparam int GAP_PCT      = 13;     // sender idles before about this many words of 100

  // one result word as seen on the out_ ports
  typedef struct packed {
    logic                      granted;
    logic                      task_valid;
    logic [csem_pkg::ID_W-1:0] woken_task;
    logic                      queue_full;
    logic                      last;
  } sem_result_t;

  // one row of the directed table; a pinned row carries its own first result
  typedef struct {
    logic                       cfg_en;
    logic [csem_pkg::CNT_W-1:0] cfg_val;
    logic [csem_pkg::CMD_W-1:0] cmd;
    logic [csem_pkg::ID_W-1:0]  id;
    logic [csem_pkg::REL_W-1:0] rel;
    logic                       pin;
    sem_result_t                res;
  } stim_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [csem_pkg::CMD_W-1:0] in_command;
  logic [csem_pkg::ID_W-1:0]  in_task_id;
  logic [csem_pkg::REL_W-1:0] in_release_count;
  logic                       out_valid;
  logic                       out_granted;
  logic                       out_task_valid;
  logic [csem_pkg::ID_W-1:0]  out_woken_task;
  logic                       out_queue_full;
  logic                       out_last;
  logic                       cfg_wr_en;
  logic [csem_pkg::CNT_W-1:0] cfg_wr_data;

  counting_semaphore_wait_queue DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_task_id       (in_task_id),
    .in_release_count (in_release_count),
    .out_valid        (out_valid),
    .out_granted      (out_granted),
    .out_task_valid   (out_task_valid),
    .out_woken_task   (out_woken_task),
    .out_queue_full   (out_queue_full),
    .out_last         (out_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  // predictor state: unit counter and ring of waiting task ids
  logic [csem_pkg::CNT_W-1:0] sem_units;
  logic [csem_pkg::ID_W-1:0]  waiter_ids [QDEPTH];
  int                         wq_head;
  int                         wq_tail;
  int                         wq_count;

  // results the block still owes, oldest first
  sem_result_t      due_results [$];
  stim_row_t        directed_rows [$];

  int               err_count;
  bit               gaps_on;

  // word currently on the input ports: pinned first result, if any
  logic             pin_word;
  sem_result_t      pin_result;

  localparam sem_result_t NO_PIN = '0;

  function automatic sem_result_t make_result(logic g, logic v,
                                              logic [csem_pkg::ID_W-1:0] t,
                                              logic f, logic l);
    sem_result_t r;
    r.granted    = g;
    r.task_valid = v;
    r.woken_task = t;
    r.queue_full = f;
    r.last       = l;
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // append one owed result at the young end
  task automatic owe_result(sem_result_t r);
    due_results = {due_results, r};
  endtask

  // register write: counter reloads and the queue empties
  task automatic reload_count(logic [csem_pkg::CNT_W-1:0] value);
    sem_units = value;
    wq_head   = 0;
    wq_tail   = 0;
    wq_count  = 0;
  endtask

  // expected results of one accepted word, with the counter and queue updated
  task automatic apply_semaphore_word(logic [csem_pkg::CMD_W-1:0] cmd,
                                      logic [csem_pkg::ID_W-1:0] id,
                                      logic [csem_pkg::REL_W-1:0] rel);
    int                       left;
    logic [csem_pkg::CNT_W:0] sum;
    left = rel;
    if (cmd == csem_pkg::CMD_WAIT) begin
      if (sem_units != '0) begin
        sem_units = sem_units - 1'b1;
        owe_result(make_result(1'b1, 1'b0, '0, 1'b0, 1'b1));
      end else if (wq_count < QDEPTH) begin
        waiter_ids[wq_tail] = id;
        wq_tail  = (wq_tail + 1) % QDEPTH;
        wq_count++;
        owe_result(make_result(1'b0, 1'b0, '0, 1'b0, 1'b1));
      end else begin
        // queue full: task dropped
        owe_result(make_result(1'b0, 1'b0, '0, 1'b1, 1'b1));
      end
    end else if (left == 0) begin
      // zero units: no effect on the state
      owe_result(make_result(1'b0, 1'b0, '0, 1'b0, 1'b1));
    end else begin
      if (wq_count == 0)
        owe_result(make_result(1'b1, 1'b0, '0, 1'b0, 1'b0));
      while (left > 0 && wq_count > 0) begin
        owe_result(make_result(1'b1, 1'b1, waiter_ids[wq_head], 1'b0, 1'b0));
        wq_head = (wq_head + 1) % QDEPTH;
        wq_count--;
        left--;
      end
      due_results[due_results.size() - 1].last = 1'b1;
      // leftover units go to the counter, which saturates
      sum = {1'b0, sem_units} + (csem_pkg::CNT_W + 1)'(left);
      sem_units = sum[csem_pkg::CNT_W] ? csem_pkg::COUNT_MAX : sum[csem_pkg::CNT_W-1:0];
    end
  endtask

  // clock, 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // monitor: check results, track register writes, predict on each accepted word
  sem_result_t got_r;
  sem_result_t want_r;
  int          word_base;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        got_r = make_result(out_granted, out_task_valid, out_woken_task,
                            out_queue_full, out_last);
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result g%0b v%0b id %h f%0b l%0b",
                                  got_r.granted, got_r.task_valid, got_r.woken_task,
                                  got_r.queue_full, got_r.last));
        end else begin
          want_r = due_results[0];
          due_results.delete(0);
          if (got_r !== want_r)
            flag_mismatch($sformatf(
              "got g%0b v%0b id %h f%0b l%0b, want g%0b v%0b id %h f%0b l%0b",
              got_r.granted, got_r.task_valid, got_r.woken_task, got_r.queue_full,
              got_r.last, want_r.granted, want_r.task_valid, want_r.woken_task,
              want_r.queue_full, want_r.last));
        end
      end
      if (cfg_wr_en)
        reload_count(cfg_wr_data);
      if (start && !busy) begin
        word_base = due_results.size();
        apply_semaphore_word(in_command, in_task_id, in_release_count);
        // pinned rows: the typed-in result stands in for the predicted one
        if (pin_word)
          due_results[word_base] = pin_result;
      end
    end
  end

  // one word on the input ports; starts and ends at a falling edge
  task automatic issue_word(logic [csem_pkg::CMD_W-1:0] cmd, logic [csem_pkg::ID_W-1:0] id,
                            logic [csem_pkg::REL_W-1:0] rel, logic pin, sem_result_t res);
    if (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    pin_word         = pin;
    pin_result       = res;
    start            <= 1'b1;
    in_command       <= cmd;
    in_task_id       <= id;
    in_release_count <= rel;
    do
      @(posedge clk);
    while (busy);
    @(negedge clk);
  endtask

  // wait until nothing is owed and the block is idle, then let latency pass
  task automatic settle();
    int waited;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while ((due_results.size() != 0 || busy) && waited < SETTLE_LIMIT);
    if (due_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", due_results.size()));
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // register write while idle; starts and ends at a falling edge
  task automatic write_count(logic [csem_pkg::CNT_W-1:0] value);
    start       <= 1'b0;
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic add_row(logic cfg_en, logic [csem_pkg::CNT_W-1:0] cfg_val,
                         logic [csem_pkg::CMD_W-1:0] cmd,
                         logic [csem_pkg::ID_W-1:0] id, logic [csem_pkg::REL_W-1:0] rel,
                         logic pin, sem_result_t res);
    stim_row_t row;
    row.cfg_en  = cfg_en;
    row.cfg_val = cfg_val;
    row.cmd     = cmd;
    row.id      = id;
    row.rel     = rel;
    row.pin     = pin;
    row.res     = res;
    directed_rows = {directed_rows, row};
  endtask

  // random word: wait_pct sets the share of waits, release sizes mostly small
  task automatic random_word(int wait_pct);
    int                         pick;
    logic [csem_pkg::ID_W-1:0]  id;
    logic [csem_pkg::REL_W-1:0] rel;
    id   = csem_pkg::ID_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10)
      rel = '0;
    else if (pick < 75)
      rel = csem_pkg::REL_W'($urandom_range(1, 4));
    else if (pick < 90)
      rel = csem_pkg::REL_W'($urandom_range(5, 20));
    else
      rel = csem_pkg::REL_W'($urandom);
    if ($urandom_range(0, 99) < wait_pct)
      issue_word(csem_pkg::CMD_WAIT, id, csem_pkg::REL_W'($urandom), 1'b0, NO_PIN);
    else
      issue_word(csem_pkg::CMD_SIGNAL, id, rel, 1'b0, NO_PIN);
  endtask

  // per-phase register value and share of waits
  logic [csem_pkg::CNT_W-1:0] phase_count [6];
  int                         phase_wait_pct [6] = '{75, 55, 40, 60, 50, 65};

  initial begin
    int i;
    int p;
    int n;

    // every input known from time zero
    rst_n            = 1'b0;
    start            = 1'b0;
    in_command       = csem_pkg::CMD_WAIT;
    in_task_id       = '0;
    in_release_count = '0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    pin_word         = 1'b0;
    pin_result       = NO_PIN;
    err_count        = 0;
    gaps_on          = 1'b1;
    reload_count('0);

    phase_count[0] = '0;
    phase_count[1] = 32'd2;
    phase_count[2] = csem_pkg::COUNT_MAX;
    phase_count[3] = '0;
    phase_count[4] = 32'h8000_0001;
    phase_count[5] = csem_pkg::CNT_W'($urandom);

    // counter is zero after reset, so the first wait queues its task
    add_row(1'b0, '0, csem_pkg::CMD_WAIT, 16'hFFFF, 16'h0000, 1'b1,
            make_result(1'b0, 1'b0, '0, 1'b0, 1'b1));
    // zero-unit signal: all fields low but last
    add_row(1'b0, '0, csem_pkg::CMD_SIGNAL, 16'h0000, 16'h0000, 1'b1,
            make_result(1'b0, 1'b0, '0, 1'b0, 1'b1));
    // wakes the one queued task
    add_row(1'b0, '0, csem_pkg::CMD_SIGNAL, 16'h0000, 16'h0001, 1'b1,
            make_result(1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b1));
    // no waiter: everything goes to the counter
    add_row(1'b0, '0, csem_pkg::CMD_SIGNAL, 16'hFFFF, 16'hFFFF, 1'b1,
            make_result(1'b1, 1'b0, '0, 1'b0, 1'b1));
    // a unit is free now
    add_row(1'b0, '0, csem_pkg::CMD_WAIT, 16'h0000, 16'hFFFF, 1'b1,
            make_result(1'b1, 1'b0, '0, 1'b0, 1'b1));
    // counter at max, more units saturate it
    add_row(1'b1, csem_pkg::COUNT_MAX, csem_pkg::CMD_SIGNAL, 16'h0000, 16'hFFFF, 1'b1,
            make_result(1'b1, 1'b0, '0, 1'b0, 1'b1));
    add_row(1'b0, '0, csem_pkg::CMD_WAIT, 16'h5555, 16'h0000, 1'b1,
            make_result(1'b1, 1'b0, '0, 1'b0, 1'b1));
    add_row(1'b0, '0, csem_pkg::CMD_SIGNAL, 16'h0000, 16'h0002, 1'b0, NO_PIN);
    // counter back to zero: fill the queue to its depth
    for (i = 0; i < QDEPTH; i++)
      add_row(i == 0, '0, csem_pkg::CMD_WAIT,
              16'hA5A0 ^ csem_pkg::ID_W'(i * 16'h1111), 16'h0000, 1'b0, NO_PIN);
    // one more wait finds the queue full
    add_row(1'b0, '0, csem_pkg::CMD_WAIT, 16'h7FFF, 16'h8000, 1'b1,
            make_result(1'b0, 1'b0, '0, 1'b1, 1'b1));
    // drain all waiters in order, units left over go to the counter
    add_row(1'b0, '0, csem_pkg::CMD_SIGNAL, 16'h0000, 16'd20, 1'b0, NO_PIN);

    // reset held from time zero, released at a falling edge
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (directed_rows[k]) begin
      if (directed_rows[k].cfg_en)
        write_count(directed_rows[k].cfg_val);
      issue_word(directed_rows[k].cmd, directed_rows[k].id, directed_rows[k].rel,
                 directed_rows[k].pin, directed_rows[k].res);
    end

    // random phases, each behind a fresh register value
    for (p = 0; p < 6; p++) begin
      write_count(phase_count[p]);
      // one phase runs with no sender gaps at all
      gaps_on = (p != 3);
      for (n = 0; n < 26; n++)
        random_word(phase_wait_pct[p]);
    end

    start <= 1'b0;
    settle();

    if (err_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
